[sv/lst_pkg.sv]
package lst_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } lst_op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_BAD  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  localparam int PosW   = 16;
  localparam int DataW  = 32;
  localparam int CountW = 7;

  // decoded operation handed from the decoder to the sequencer
  typedef struct packed {
    lst_op_t    op;
    logic [1:0] status;
    logic       shift;
  } lst_cmd_t;

endpackage

[sv/lst_in_if.sv]
interface lst_in_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        opcode;
  logic signed [lst_pkg::PosW-1:0]   position;
  logic signed [lst_pkg::DataW-1:0]  data_in;

  modport source (output valid, output opcode, output position, output data_in,
                  input ready);
  modport sink   (input valid, input opcode, input position, input data_in,
                  output ready);
endinterface

[sv/lst_out_if.sv]
interface lst_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [lst_pkg::DataW-1:0]   data_out;
  logic [1:0]                         status;
  logic [lst_pkg::CountW-1:0]         entry_count;

  modport source (output valid, output data_out, output status, output entry_count,
                  input ready);
  modport sink   (input valid, input data_out, input status, input entry_count,
                  output ready);
endinterface

[sv/lst_ram.sv]
module lst_ram #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [lst_pkg::DataW-1:0] wdata,
  input  logic                      re,
  input  logic [AW-1:0]             raddr,
  output logic [lst_pkg::DataW-1:0] rdata
);

  logic [lst_pkg::DataW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/lst_decode.sv]
module lst_decode #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int CW    = 7
) (
  input  lst_pkg::lst_op_t                 op,
  input  logic signed [lst_pkg::PosW-1:0]  position,
  input  logic [CW-1:0]                    count,
  output lst_pkg::lst_cmd_t                cmd,
  output logic [AW-1:0]                    at,
  output logic [AW-1:0]                    first,
  output logic [AW-1:0]                    last
);

  localparam int CMPW = ((CW > lst_pkg::PosW - 1) ? CW : lst_pkg::PosW - 1) + 1;

  logic            pos_neg;
  logic            pos_m1;
  logic [CMPW-1:0] pos_u;
  logic [CMPW-1:0] cnt_u;
  logic [CMPW-1:0] cm1_u;
  logic            past_end;
  logic            past_last;
  logic            empty;
  logic            full;

  assign pos_neg   = position[lst_pkg::PosW-1];
  assign pos_m1    = (position == -16'sd1);
  assign pos_u     = CMPW'(position[lst_pkg::PosW-2:0]);
  assign cnt_u     = CMPW'(count);
  assign cm1_u     = cnt_u - CMPW'(1);
  assign past_end  = (pos_u >= cnt_u);
  assign past_last = (pos_u >= cm1_u);
  assign empty     = (count == '0);
  assign full      = (count == CW'(DEPTH));

  always_comb begin
    cmd.op     = op;
    cmd.status = lst_pkg::ST_OK;
    cmd.shift  = 1'b0;
    at         = '0;
    first      = '0;
    last       = '0;
    case (op)
      lst_pkg::OP_INSERT: begin
        if (pos_neg && !pos_m1) begin
          cmd.status = lst_pkg::ST_BAD;
        end else if (full) begin
          cmd.status = lst_pkg::ST_FULL;
        end
        at        = (pos_m1 || past_end) ? AW'(cnt_u) : AW'(pos_u);
        cmd.shift = !(pos_m1 || past_end);
        // descending copy: count-1 down to at
        first     = AW'(cm1_u);
        last      = at;
      end
      lst_pkg::OP_REMOVE: begin
        if (empty) begin
          cmd.status = lst_pkg::ST_BAD;
        end
        if (pos_neg || pos_u == '0) begin
          at = '0;
        end else if (past_last) begin
          at = AW'(cm1_u);
        end else begin
          at = AW'(pos_u);
        end
        cmd.shift = (at != AW'(cm1_u));
        // ascending copy: at+1 up to count-1
        first     = AW'(at + 1'b1);
        last      = AW'(cm1_u);
      end
      lst_pkg::OP_READ: begin
        if (empty || (!pos_neg && past_end)) begin
          cmd.status = lst_pkg::ST_BAD;
        end
        at = pos_neg ? '0 : AW'(pos_u);
      end
      default: begin
        cmd.status = lst_pkg::ST_BAD;
      end
    endcase
  end

endmodule

[sv/indexed_list_engine.sv]
// Indexed list engine: an ordered list of up to DEPTH signed 32-bit values
// held in a single-port-write, single-port-read RAM.
//
// in_bus  : one beat carries opcode (insert/remove/read), position, data_in.
// out_bus : one beat per input beat with data_out, status and entry_count.
// Both channels use valid/ready; a beat moves when both are high.
//
// Sequencing: a read or any rejected operation goes from accept straight to
// the finish state. An append goes through the put state, any other insert
// through shift, drain and put. A remove at the tail goes straight to finish,
// else through shift. The shift loop moves one entry per cycle through the
// RAM (one read, one write port). in_ready is high only while the sequencer
// is idle; one operation is in flight at a time.
//
// The result sits in an output register, so a new beat can be accepted
// while out_bus is stalled; that next operation then waits in its final
// state until the output register is free.
// Reset clears the entry count and control state; the RAM is not cleared,
// entries beyond count never reach data_out.
module indexed_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  lst_in_if.sink    in_bus,
  lst_out_if.source out_bus
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_DRAIN,
    S_PUT,
    S_FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  lst_pkg::lst_op_t          op_r, op_nxt;
  logic [1:0]                status_r, status_nxt;
  logic [lst_pkg::DataW-1:0] val_r, val_nxt;
  logic [AW-1:0]             at_r, at_nxt;
  logic [AW-1:0]             ptr_r, ptr_nxt;
  logic [AW-1:0]             last_r, last_nxt;
  logic                      wb_valid_r, wb_valid_nxt;
  logic [AW-1:0]             wb_addr_r, wb_addr_nxt;
  logic [CW-1:0]             count_r, count_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [lst_pkg::DataW-1:0]  out_data_r, out_data_nxt;
  logic [1:0]                 out_status_r, out_status_nxt;
  logic [lst_pkg::CountW-1:0] out_count_r, out_count_nxt;

  lst_pkg::lst_cmd_t         dec_cmd;
  logic [AW-1:0]             dec_at;
  logic [AW-1:0]             dec_first;
  logic [AW-1:0]             dec_last;

  logic                      accept;
  logic                      is_ins;
  logic                      out_free;

  logic                      ram_we;
  logic [AW-1:0]             ram_waddr;
  logic [lst_pkg::DataW-1:0] ram_wdata;
  logic                      ram_re;
  logic [AW-1:0]             ram_raddr;
  logic [lst_pkg::DataW-1:0] ram_rdata;

  lst_decode #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_decode (
    .op       (lst_pkg::lst_op_t'(in_bus.opcode)),
    .position (in_bus.position),
    .count    (count_r),
    .cmd      (dec_cmd),
    .at       (dec_at),
    .first    (dec_first),
    .last     (dec_last)
  );

  lst_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_bus.ready        = (state_r == S_IDLE);
  assign accept              = in_bus.valid && in_bus.ready;
  assign is_ins              = (op_r == lst_pkg::OP_INSERT);
  assign out_free            = !out_valid_r || out_bus.ready;

  assign out_bus.valid       = out_valid_r;
  assign out_bus.data_out    = out_data_r;
  assign out_bus.status      = out_status_r;
  assign out_bus.entry_count = out_count_r;

  // Write port: copy-back of the entry read last cycle, or the new value.
  assign ram_we    = wb_valid_r || (state_r == S_PUT);
  assign ram_waddr = (state_r == S_PUT) ? at_r : wb_addr_r;
  assign ram_wdata = (state_r == S_PUT) ? val_r : ram_rdata;
  // Read port: the read target at accept, then the shift pointer.
  assign ram_re    = accept || (state_r == S_SHIFT);
  assign ram_raddr = (state_r == S_SHIFT) ? ptr_r : dec_at;

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    status_nxt     = status_r;
    val_nxt        = val_r;
    at_nxt         = at_r;
    ptr_nxt        = ptr_r;
    last_nxt       = last_r;
    wb_valid_nxt   = 1'b0;
    wb_addr_nxt    = wb_addr_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = dec_cmd.op;
          status_nxt = dec_cmd.status;
          val_nxt    = in_bus.data_in;
          at_nxt     = dec_at;
          ptr_nxt    = dec_first;
          last_nxt   = dec_last;
          if (dec_cmd.status != lst_pkg::ST_OK) begin
            state_nxt = S_FINISH;
          end else if (dec_cmd.op == lst_pkg::OP_INSERT) begin
            state_nxt = dec_cmd.shift ? S_SHIFT : S_PUT;
          end else if (dec_cmd.op == lst_pkg::OP_REMOVE) begin
            state_nxt = dec_cmd.shift ? S_SHIFT : S_FINISH;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        // one entry per cycle: read ptr now, write it one place over next cycle
        wb_valid_nxt = 1'b1;
        wb_addr_nxt  = is_ins ? AW'(ptr_r + 1'b1) : AW'(ptr_r - 1'b1);
        ptr_nxt      = is_ins ? AW'(ptr_r - 1'b1) : AW'(ptr_r + 1'b1);
        if (ptr_r == last_r) begin
          state_nxt = is_ins ? S_DRAIN : S_FINISH;
        end
      end
      S_DRAIN: begin
        state_nxt = S_PUT;
      end
      S_PUT: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          if (status_r == lst_pkg::ST_OK && op_r == lst_pkg::OP_INSERT) begin
            count_nxt = CW'(count_r + 1'b1);
          end else if (status_r == lst_pkg::ST_OK && op_r == lst_pkg::OP_REMOVE) begin
            count_nxt = CW'(count_r - 1'b1);
          end
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_data_nxt   = (status_r == lst_pkg::ST_OK && op_r == lst_pkg::OP_READ) ?
                           ram_rdata : '0;
          out_count_nxt  = lst_pkg::CountW'(count_nxt);
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wb_valid_r  <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wb_valid_r  <= wb_valid_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    status_r     <= status_nxt;
    val_r        <= val_nxt;
    at_r         <= at_nxt;
    ptr_r        <= ptr_nxt;
    last_r       <= last_nxt;
    wb_addr_r    <= wb_addr_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
  end

  // list never grows past the store
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  // copy-back write only follows a shift read
  a_wb_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
    wb_valid_r |-> $past(state_r == S_SHIFT))
    else $error("copy-back without shift read");

  // new value write never collides with a copy-back
  a_put_no_wb: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PUT) |-> !wb_valid_r)
    else $error("write port conflict");

  // a result is only launched from the finish state
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FINISH))
    else $error("result without finish");

  // full status only reported with the list at depth
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(out_valid_r) && out_status_r == lst_pkg::ST_FULL) |-> count_r == CW'(DEPTH))
    else $error("full status with room left");

endmodule
